// ===== src/mclx_pkg.sv =====
package mclx_pkg;

   localparam int TEXT_CAPACITY = 32;
   // kept text length, capped so that it fits the 5-bit length fields
   localparam int KEEP_LEN = (TEXT_CAPACITY - 1 > 31) ? 31 : TEXT_CAPACITY - 1;
   localparam int ADDR_W   = $clog2(KEEP_LEN);
   localparam int CNT_W    = $clog2(KEEP_LEN + 1);

   localparam logic [3:0] KIND_INT       = 4'd0;
   localparam logic [3:0] KIND_IDENT     = 4'd1;
   localparam logic [3:0] KIND_NUMBER    = 4'd2;
   localparam logic [3:0] KIND_ASSIGN    = 4'd3;
   localparam logic [3:0] KIND_PLUS      = 4'd4;
   localparam logic [3:0] KIND_MINUS     = 4'd5;
   localparam logic [3:0] KIND_IF        = 4'd6;
   localparam logic [3:0] KIND_EQUAL     = 4'd7;
   localparam logic [3:0] KIND_LBRACE    = 4'd8;
   localparam logic [3:0] KIND_RBRACE    = 4'd9;
   localparam logic [3:0] KIND_LPAREN    = 4'd10;
   localparam logic [3:0] KIND_RPAREN    = 4'd11;
   localparam logic [3:0] KIND_SEMICOLON = 4'd12;
   localparam logic [3:0] KIND_EOF       = 4'd13;

   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_DIG_0  = 8'h30;
   localparam logic [7:0] CH_DIG_9  = 8'h39;
   localparam logic [7:0] CH_I      = 8'h69;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] text_char;
      logic [4:0] char_position;
      logic [4:0] text_length;
      logic       token_end;
      logic       run_last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_IDENT = 4'b0010,
      MODE_NUM   = 4'b0100,
      MODE_EQ    = 4'b1000
   } lex_mode_type;

   // work planned for one accepted byte: a stored token, then up to two literal tokens
   typedef struct packed {
      logic              mem_v;
      logic [3:0]        mem_kind;
      logic [CNT_W-1:0]  mem_len;
      logic              lit1_v;
      logic [3:0]        lit1_kind;
      logic              lit1_two;
      logic              lit2_v;
      logic [3:0]        lit2_kind;
      logic              lit2_eof;
      logic [7:0]        lit2_char;
      logic              wr_v;
      logic              wr_defer;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      lex_mode_type      next_mode;
      logic [CNT_W-1:0]  next_count;
      logic              next_int;
      logic              next_if;
   } plan_type;

endpackage

// ===== src/mclx_ram.sv =====
module mclx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mclx_plan.sv =====
module mclx_plan import mclx_pkg::*; (
   input  req_payload_type  req_payload,
   input  lex_mode_type     mode,
   input  logic [CNT_W-1:0] count,
   input  logic             int_match,
   input  logic             if_match,
   output plan_type         plan
);

   logic [7:0] c;
   logic       alpha;
   logic       digit;
   logic       punct;
   logic [3:0] punct_kind;
   logic [3:0] ident_kind;
   logic       do_flush;
   logic       do_idle;

   assign c     = req_payload.char_code;
   assign alpha = (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   assign digit = (c >= CH_DIG_0 && c <= CH_DIG_9);

   always_comb begin
      punct      = 1'b1;
      punct_kind = KIND_PLUS;
      case (c)
         CH_PLUS:   punct_kind = KIND_PLUS;
         CH_MINUS:  punct_kind = KIND_MINUS;
         CH_LBRACE: punct_kind = KIND_LBRACE;
         CH_RBRACE: punct_kind = KIND_RBRACE;
         CH_LPAREN: punct_kind = KIND_LPAREN;
         CH_RPAREN: punct_kind = KIND_RPAREN;
         CH_SEMI:   punct_kind = KIND_SEMICOLON;
         default:   punct      = 1'b0;
      endcase
   end

   always_comb begin
      if (count == CNT_W'(3) && int_match) begin
         ident_kind = KIND_INT;
      end else if (count == CNT_W'(2) && if_match) begin
         ident_kind = KIND_IF;
      end else begin
         ident_kind = KIND_IDENT;
      end
   end

   always_comb begin
      plan            = '0;
      plan.next_mode  = mode;
      plan.next_count = count;
      plan.next_int   = int_match;
      plan.next_if    = if_match;
      do_flush        = 1'b0;
      do_idle         = 1'b0;

      if (req_payload.end_of_input) begin
         do_flush       = 1'b1;
         plan.lit2_v    = 1'b1;
         plan.lit2_kind = KIND_EOF;
         plan.lit2_eof  = 1'b1;
      end else begin
         case (mode)
            MODE_IDENT, MODE_NUM: begin
               if (digit || (alpha && mode == MODE_IDENT)) begin
                  // extend the token; bytes past the kept length are dropped
                  if (count < CNT_W'(KEEP_LEN)) begin
                     plan.wr_v       = 1'b1;
                     plan.wr_addr    = count[ADDR_W-1:0];
                     plan.wr_data    = c;
                     plan.next_count = count + CNT_W'(1);
                     plan.next_int   = int_match &&
                        ((count == CNT_W'(1) && c == CH_N) || (count == CNT_W'(2) && c == CH_T));
                     plan.next_if    = if_match && count == CNT_W'(1) && c == CH_F;
                  end
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_EQ: begin
               if (c == CH_EQ) begin
                  plan.lit1_v     = 1'b1;
                  plan.lit1_kind  = KIND_EQUAL;
                  plan.lit1_two   = 1'b1;
                  plan.next_mode  = MODE_IDLE;
                  plan.next_count = '0;
               end else begin
                  do_flush = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase
      end

      if (do_flush) begin
         case (mode)
            MODE_IDENT: begin
               plan.mem_v    = 1'b1;
               plan.mem_kind = ident_kind;
               plan.mem_len  = count;
            end
            MODE_NUM: begin
               plan.mem_v    = 1'b1;
               plan.mem_kind = KIND_NUMBER;
               plan.mem_len  = count;
            end
            MODE_EQ: begin
               plan.lit1_v    = 1'b1;
               plan.lit1_kind = KIND_ASSIGN;
            end
            default: ;
         endcase
         plan.next_mode  = MODE_IDLE;
         plan.next_count = '0;
      end

      if (do_idle) begin
         if (alpha || digit) begin
            plan.wr_v       = 1'b1;
            plan.wr_addr    = '0;
            plan.wr_data    = c;
            plan.next_mode  = alpha ? MODE_IDENT : MODE_NUM;
            plan.next_count = CNT_W'(1);
            plan.next_int   = (c == CH_I);
            plan.next_if    = (c == CH_I);
         end else if (c == CH_EQ) begin
            plan.next_mode = MODE_EQ;
         end else if (punct) begin
            plan.lit2_v    = 1'b1;
            plan.lit2_kind = punct_kind;
            plan.lit2_char = c;
         end
      end

      // the first byte of a new token must wait until the old text is read out
      plan.wr_defer = plan.mem_v && plan.wr_v;
   end

endmodule

// ===== src/mclx_seq.sv =====
module mclx_seq import mclx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  plan_type          plan,
   output logic              busy,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              defer_wr,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_payload
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_MEM_REQ = 5'b00010,
      ST_MEM_OUT = 5'b00100,
      ST_LIT1    = 5'b01000,
      ST_LIT2    = 5'b10000
   } seq_state_type;

   seq_state_type    state_ff, state_in;
   plan_type         plan_ff, plan_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic             load;
   logic             slot_free;
   logic             tok_end;
   seq_state_type    after_mem;
   seq_state_type    after_lit1;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign after_mem  = plan_ff.lit1_v ? ST_LIT1 : (plan_ff.lit2_v ? ST_LIT2 : ST_IDLE);
   assign after_lit1 = plan_ff.lit2_v ? ST_LIT2 : ST_IDLE;

   always_comb begin
      state_in       = state_ff;
      plan_in        = plan_ff;
      pos_in         = pos_ff;
      rsp_payload_in = rsp_payload_ff;
      load           = 1'b0;
      tok_end        = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = pos_ff[ADDR_W-1:0];
      defer_wr       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               plan_in = plan;
               pos_in  = '0;
               if (plan.mem_v) begin
                  state_in = ST_MEM_REQ;
               end else if (plan.lit1_v) begin
                  state_in = ST_LIT1;
               end else begin
                  state_in = ST_LIT2;
               end
            end
         end
         ST_MEM_REQ: begin
            rd_en    = 1'b1;
            state_in = ST_MEM_OUT;
         end
         ST_MEM_OUT: begin
            if (slot_free) begin
               load    = 1'b1;
               tok_end = (pos_ff == plan_ff.mem_len - CNT_W'(1));
               rsp_payload_in.token_kind    = plan_ff.mem_kind;
               rsp_payload_in.text_char     = rd_data;
               rsp_payload_in.char_position = 5'(pos_ff);
               rsp_payload_in.text_length   = 5'(plan_ff.mem_len);
               rsp_payload_in.token_end     = tok_end;
               rsp_payload_in.run_last      = tok_end && !plan_ff.lit1_v && !plan_ff.lit2_v;
               if (tok_end) begin
                  pos_in   = '0;
                  state_in = after_mem;
                  defer_wr = plan_ff.wr_defer;
               end else begin
                  // fetch the next character while this one goes out
                  pos_in  = pos_ff + CNT_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = pos_in[ADDR_W-1:0];
               end
            end
         end
         ST_LIT1: begin
            if (slot_free) begin
               load    = 1'b1;
               tok_end = !plan_ff.lit1_two || pos_ff[0];
               rsp_payload_in.token_kind    = plan_ff.lit1_kind;
               rsp_payload_in.text_char     = CH_EQ;
               rsp_payload_in.char_position = {4'd0, pos_ff[0]};
               rsp_payload_in.text_length   = plan_ff.lit1_two ? 5'd2 : 5'd1;
               rsp_payload_in.token_end     = tok_end;
               rsp_payload_in.run_last      = tok_end && !plan_ff.lit2_v;
               if (tok_end) begin
                  pos_in   = '0;
                  state_in = after_lit1;
               end else begin
                  pos_in = pos_ff + CNT_W'(1);
               end
            end
         end
         ST_LIT2: begin
            if (slot_free) begin
               load = 1'b1;
               rsp_payload_in.token_kind    = plan_ff.lit2_kind;
               rsp_payload_in.text_char     = plan_ff.lit2_eof ? 8'd0 : plan_ff.lit2_char;
               rsp_payload_in.char_position = 5'd0;
               rsp_payload_in.text_length   = plan_ff.lit2_eof ? 5'd0 : 5'd1;
               rsp_payload_in.token_end     = 1'b1;
               rsp_payload_in.run_last      = 1'b1;
               state_in = ST_IDLE;
               defer_wr = plan_ff.wr_defer;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      plan_ff        <= plan_in;
      pos_ff         <= pos_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/mini_c_lexer_unit.sv =====
// Streaming tokenizer for a small C-like language.
// req channel: one source byte per transfer, or an end-of-input mark that
// flushes any pending token and then gives an empty EOF token.
// rsp channel: each finished token as a run of transfers, one per stored
// character, with its kind, position, stored length and end flags.
// Bytes that only extend an identifier or a number are taken one per cycle
// while req_ready is high and give no result. A byte that closes a stored
// token starts a run: the memory read is registered and the output register
// takes it; then one result per cycle while the receiver keeps up. Literal
// tokens ('=', '==', punctuation, EOF) give one result per character.
// req_ready drops while a run is being produced. The rate is set by the
// single read port of the text memory, one character a cycle. A stall on
// rsp holds the output register and the sequencer. Reset clears the mode
// and the stored length and leaves the text memory as it is: no clearing
// pass is needed, since text is read only after written.
module mini_c_lexer_unit import mclx_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   lex_mode_type     mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             int_ff, int_in;
   logic             if_ff, if_in;
   plan_type         plan;
   logic             accept;
   logic             start;
   logic             busy;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic             defer_wr;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [7:0]       defer_data_ff, defer_data_in;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (plan.mem_v || plan.lit1_v || plan.lit2_v);

   mclx_plan u_plan (
      .req_payload (req_payload),
      .mode        (mode_ff),
      .count       (count_ff),
      .int_match   (int_ff),
      .if_match    (if_ff),
      .plan        (plan)
   );

   mclx_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .plan        (plan),
      .busy        (busy),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .defer_wr    (defer_wr),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // hold the opening byte of the next token until the old text has gone out
   assign defer_data_in = (accept && plan.wr_defer) ? plan.wr_data : defer_data_ff;

   always_comb begin
      if (defer_wr) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = defer_data_ff;
      end else begin
         wr_en   = accept && plan.wr_v && !plan.wr_defer;
         wr_addr = plan.wr_addr;
         wr_data = plan.wr_data;
      end
   end

   mclx_ram #(
      .WIDTH (8),
      .DEPTH (KEEP_LEN)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      int_in   = int_ff;
      if_in    = if_ff;
      if (accept) begin
         mode_in  = plan.next_mode;
         count_in = plan.next_count;
         int_in   = plan.next_int;
         if_in    = plan.next_if;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         int_ff   <= 1'b0;
         if_ff    <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         int_ff   <= int_in;
         if_ff    <= if_in;
      end
      defer_data_ff <= defer_data_in;
   end

endmodule

// ===== src/mclx_checker.sv =====
module mclx_checker import mclx_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // hold a request until its transfer
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("req valid dropped before transfer");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   a_pos_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.text_length != 5'd0 |->
         (rsp_payload.token_end ==
          (5'(rsp_payload.char_position + 5'd1) == rsp_payload.text_length)))
      else $error("token_end does not match position and length");

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.run_last |-> rsp_payload.token_end)
      else $error("run_last without token_end");

   a_eof_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.token_kind == KIND_EOF |->
         rsp_payload.text_length == 5'd0 && rsp_payload.text_char == 8'd0 &&
         rsp_payload.run_last)
      else $error("malformed EOF token");

endmodule

bind mini_c_lexer_unit mclx_checker u_mclx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
